// ===== hw/rtl/lbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lbp_pkg;

  // field widths
  localparam int PIX_W     = 8;
  localparam int BIN_W     = 8;
  localparam int CNT_W     = 21;
  localparam int CMD_W     = 2;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int NUM_BINS  = 256;

  // default frame limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // register reset values and saturation limit
  localparam logic [CFG_W-1:0] CFG_SIZE_RST = 11'd64;
  localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

  // result kinds
  localparam logic KIND_CODE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL = 2'd0,
    CMD_DRAIN = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  // histogram operations
  typedef enum logic [1:0] {
    HOP_CODE  = 2'd0,
    HOP_READ  = 2'd1,
    HOP_CLEAR = 2'd2
  } hop_e;

  // one window column: three pixels with their in-frame flags
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    logic             top_ok;
    logic             mid_ok;
    logic             bot_ok;
    logic             first;
    logic             lastc;
  } col_t;

  // request into the histogram stages
  typedef struct packed {
    logic             valid;
    hop_e             op;
    logic [BIN_W-1:0] addr;
    logic             last;
  } hist_req_t;

  // one result word
  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] code;
    logic [CNT_W-1:0] count;
    logic             frame_done;
  } res_t;

  // first pipeline stage payload
  typedef struct packed {
    logic             line;
    logic             read;
    logic             clr;
    logic             emit;
    logic             last;
    logic [PIX_W-1:0] pix;
    logic [BIN_W-1:0] bin;
    logic             top_ok;
    logic             mid_ok;
    logic             bot_ok;
    logic             first;
    logic             lastc;
  } s1_t;

  // second pipeline stage payload
  typedef struct packed {
    logic             read;
    logic             clr;
    logic             emit;
    logic             last;
    logic [BIN_W-1:0] bin;
  } s2_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lbp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port, read before write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbp_cell (
  input  wire logic                     clk_i,
  input  wire logic                     shift_i,
  input  wire lbp_pkg::col_t            col_i,
  input  wire logic [lbp_pkg::PIX_W-1:0] centre_i,
  output lbp_pkg::col_t                 col_o,
  output logic [2:0]                    ge_o
);

  lbp_pkg::col_t col_q;

  // column register, takes the neighbour's column on every shift
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  // neighbour versus centre, masked by the row flags
  assign ge_o[0] = col_q.top_ok && (col_q.top >= centre_i);
  assign ge_o[1] = col_q.mid_ok && (col_q.mid >= centre_i);
  assign ge_o[2] = col_q.bot_ok && (col_q.bot >= centre_i);

  assign col_o = col_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_hist.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbp_hist (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire lbp_pkg::hist_req_t req_i,
  output logic                    res_valid_o,
  output lbp_pkg::res_t           res_o
);

  lbp_pkg::hist_req_t s3_q;
  lbp_pkg::hist_req_t s4_q;

  logic [lbp_pkg::NUM_BINS-1:0] valid_q;
  logic [lbp_pkg::NUM_BINS-1:0] valid_d;

  logic                      rd_en;
  logic [lbp_pkg::CNT_W-1:0] rdata;
  logic                      wr_en;
  logic [lbp_pkg::CNT_W-1:0] cur;
  logic [lbp_pkg::CNT_W-1:0] inc;
  logic                      clear;
  logic                      fwd_q;
  logic [lbp_pkg::CNT_W-1:0] fwd_data_q;

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q    <= '0;
      s4_q    <= '0;
      valid_q <= '0;
    end else begin
      if (adv_i) begin
        s3_q <= req_i;
        s4_q <= s3_q;
      end
      valid_q <= valid_d;
    end
  end

  assign rd_en = adv_i && s3_q.valid && (s3_q.op != lbp_pkg::HOP_CLEAR);
  assign clear = adv_i && s3_q.valid && (s3_q.op == lbp_pkg::HOP_CLEAR);
  assign wr_en = adv_i && s4_q.valid && (s4_q.op == lbp_pkg::HOP_CODE);

  // bypass when the bin is written on the edge it is read
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      fwd_q      <= wr_en && (s4_q.addr == s3_q.addr);
      fwd_data_q <= inc;
    end
  end

  // per-bin valid flags, a new frame clears them all at once
  always_comb begin
    valid_d = valid_q;
    if (clear) begin
      valid_d = '0;
    end else if (wr_en) begin
      valid_d[s4_q.addr] = 1'b1;
    end
  end

  // current count and saturating increment
  always_comb begin
    if (fwd_q) begin
      cur = fwd_data_q;
    end else if (valid_q[s4_q.addr]) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
    inc = (cur == lbp_pkg::CNT_MAX) ? cur : cur + lbp_pkg::CNT_W'(1);
  end

  lbp_ram #(
    .WIDTH (lbp_pkg::CNT_W),
    .DEPTH (lbp_pkg::NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s4_q.addr),
    .wdata_i (inc),
    .re_i    (rd_en),
    .raddr_i (s3_q.addr),
    .rdata_o (rdata)
  );

  // result word
  always_comb begin
    res_valid_o = s4_q.valid && (s4_q.op != lbp_pkg::HOP_CLEAR);
    res_o.code  = s4_q.addr;
    if (s4_q.op == lbp_pkg::HOP_READ) begin
      res_o.kind       = lbp_pkg::KIND_COUNT;
      res_o.count      = cur;
      res_o.frame_done = 1'b0;
    end else begin
      res_o.kind       = lbp_pkg::KIND_CODE;
      res_o.count      = '0;
      res_o.frame_done = s4_q.last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_image_with_histogram_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming 3x3 local binary pattern with a 256-bin histogram. One word is taken
// per clock on the input channel whatever its command while in_ready_o is high,
// and a result goes through the first, second and both histogram stages and the
// output buffer. The rate is set by the line store (one read and one write per
// cycle in a single RAM holding the two previous rows), the three-column window
// cells that shift once per pixel or drain word, and the histogram RAM, whose
// read-modify-write is split over a read stage and a write stage with a bypass
// for back-to-back hits on one bin. A two-word output buffer lets the input
// keep flowing while a result waits; in_ready_o drops only while both buffer
// words are full. Bins clear when a frame's opening pixel reaches the histogram,
// so there is no clearing pass. Frame size registers latch when a frame starts.
module lbp_image_with_histogram_top #(
  parameter int MAX_WIDTH  = lbp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lbp_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [lbp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [lbp_pkg::CFG_W-1:0]    cfg_data_i,
  // input words
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [lbp_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [lbp_pkg::PIX_W-1:0]    pixel_i,
  input  wire logic [lbp_pkg::BIN_W-1:0]    bin_i,
  // result words
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              kind_o,
  output logic [lbp_pkg::PIX_W-1:0]         code_o,
  output logic [lbp_pkg::CNT_W-1:0]         count_o,
  output logic                              frame_done_o
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CIW = $clog2(MAX_WIDTH);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int CWW = (WW > lbp_pkg::CFG_W) ? WW : lbp_pkg::CFG_W;
  localparam int CHW = (HW > lbp_pkg::CFG_W) ? HW : lbp_pkg::CFG_W;
  localparam int LBW = 2 * lbp_pkg::PIX_W;
  localparam int NCELLS = 3;

  // configuration registers
  logic [lbp_pkg::CFG_W-1:0] cfg_w_q;
  logic [lbp_pkg::CFG_W-1:0] cfg_h_q;

  // frame state
  logic          active_q;
  logic [CIW-1:0] cin_q;
  logic [RW-1:0]  rin_q;
  logic [WW-1:0]  w_q;
  logic [HW-1:0]  h_q;

  logic           adv;
  logic           acc;
  logic           start;
  logic           pix_take;
  logic           drn_take;
  logic           line_take;
  logic           rd_take;
  logic [CWW-1:0] cfg_w_ext;
  logic [CHW-1:0] cfg_h_ext;
  logic [WW-1:0]  w_clamp;
  logic [HW-1:0]  h_clamp;
  logic [WW-1:0]  w_e;
  logic [HW-1:0]  h_e;
  logic [CIW-1:0] cin_e;
  logic [RW-1:0]  rin_e;
  logic [CIW-1:0] w_m1;
  logic           lastc;
  logic           emit;
  logic           lastk;
  logic [RW-1:0]  h_r;

  // pipeline
  logic           s1_valid_q;
  lbp_pkg::s1_t   s1_q;
  logic [CIW-1:0] s1_cin_q;
  logic           s2_valid_q;
  lbp_pkg::s2_t   s2_q;

  // line store
  logic           lb_we;
  logic [LBW-1:0] lb_wdata;
  logic [LBW-1:0] lb_rdata;
  logic           lb_re;
  logic           lb_fwd_q;
  logic [LBW-1:0] lb_fwd_data_q;
  logic [LBW-1:0] s1_line;

  // window cells
  lbp_pkg::col_t             col_in;
  lbp_pkg::col_t             col    [NCELLS];
  logic [2:0]                ge     [NCELLS];
  logic                      shift;
  logic [lbp_pkg::PIX_W-1:0] centre;
  logic [lbp_pkg::PIX_W-1:0] lbp;

  // histogram and output buffer
  lbp_pkg::hist_req_t hist_req;
  logic               res_valid;
  lbp_pkg::res_t      res;
  logic [1:0]         ob_cnt_q;
  logic [1:0]         ob_cnt_d;
  lbp_pkg::res_t      ob0_q;
  lbp_pkg::res_t      ob0_d;
  lbp_pkg::res_t      ob1_q;
  lbp_pkg::res_t      ob1_d;
  logic               push;
  logic               pop;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= lbp_pkg::CFG_SIZE_RST;
      cfg_h_q <= lbp_pkg::CFG_SIZE_RST;
    end else if (cfg_valid_i) begin
      unique case (lbp_pkg::reg_idx_e'(cfg_index_i))
        lbp_pkg::REG_FRAME_WIDTH:  cfg_w_q <= cfg_data_i;
        lbp_pkg::REG_FRAME_HEIGHT: cfg_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame size saturated into range
  always_comb begin
    cfg_w_ext = CWW'(cfg_w_q);
    cfg_h_ext = CHW'(cfg_h_q);
    if (cfg_w_ext == '0) begin
      w_clamp = WW'(1);
    end else if (cfg_w_ext > CWW'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(cfg_w_ext);
    end
    if (cfg_h_ext == '0) begin
      h_clamp = HW'(1);
    end else if (cfg_h_ext > CHW'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(cfg_h_ext);
    end
  end

  // word decode and position of the incoming column
  assign adv        = (ob_cnt_q != 2'd2);
  assign in_ready_o = adv;
  assign acc        = in_valid_i && adv;

  always_comb begin
    start     = (cmd_i == lbp_pkg::CMD_PIXEL) && !active_q;
    w_e       = start ? w_clamp : w_q;
    h_e       = start ? h_clamp : h_q;
    cin_e     = start ? '0 : cin_q;
    rin_e     = start ? '0 : rin_q;
    h_r       = RW'(h_e);
    pix_take  = (cmd_i == lbp_pkg::CMD_PIXEL) && (start || (rin_q < RW'(h_q)));
    drn_take  = (cmd_i == lbp_pkg::CMD_DRAIN) && active_q && (rin_q >= RW'(h_q));
    line_take = pix_take || drn_take;
    rd_take   = (cmd_i == lbp_pkg::CMD_READ);
    w_m1      = CIW'(w_e - WW'(1));
    lastc     = (cin_e == w_m1);
    emit      = (rin_e > RW'(1)) || ((rin_e == RW'(1)) && (cin_e != '0));
    lastk     = (rin_e == h_r + RW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cin_q    <= '0;
      rin_q    <= '0;
      w_q      <= WW'(lbp_pkg::CFG_SIZE_RST);
      h_q      <= HW'(lbp_pkg::CFG_SIZE_RST);
    end else if (acc) begin
      if (start) begin
        active_q <= 1'b1;
        w_q      <= w_clamp;
        h_q      <= h_clamp;
      end
      if (line_take) begin
        cin_q <= lastc ? '0 : cin_e + CIW'(1);
        rin_q <= lastc ? rin_e + RW'(1) : rin_e;
        if (lastk) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  // first stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= acc && (line_take || rd_take);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q.line   <= line_take;
      s1_q.read   <= rd_take;
      s1_q.clr    <= start;
      s1_q.emit   <= emit;
      s1_q.last   <= lastk;
      s1_q.pix    <= pixel_i;
      s1_q.bin    <= bin_i;
      s1_q.top_ok <= (rin_e >= RW'(2));
      s1_q.mid_ok <= (rin_e >= RW'(1)) && (rin_e <= h_r);
      s1_q.bot_ok <= (rin_e < h_r);
      s1_q.first  <= (cin_e == '0);
      s1_q.lastc  <= lastc;
      s1_cin_q    <= cin_e;
    end
  end

  // line store: upper byte two rows back, lower byte one row back
  assign lb_re    = acc && line_take;
  assign lb_we    = adv && s1_valid_q && s1_q.line;
  assign s1_line  = lb_fwd_q ? lb_fwd_data_q : lb_rdata;
  assign lb_wdata = {s1_line[lbp_pkg::PIX_W-1:0], s1_q.pix};

  always_ff @(posedge clk_i) begin
    if (lb_re) begin
      lb_fwd_q      <= lb_we && (s1_cin_q == cin_e);
      lb_fwd_data_q <= lb_wdata;
    end
  end

  lbp_ram #(
    .WIDTH (LBW),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (s1_cin_q),
    .wdata_i (lb_wdata),
    .re_i    (lb_re),
    .raddr_i (cin_e),
    .rdata_o (lb_rdata)
  );

  // incoming column for the window
  always_comb begin
    col_in.top    = s1_line[LBW-1:lbp_pkg::PIX_W];
    col_in.mid    = s1_line[lbp_pkg::PIX_W-1:0];
    col_in.bot    = s1_q.pix;
    col_in.top_ok = s1_q.top_ok;
    col_in.mid_ok = s1_q.mid_ok;
    col_in.bot_ok = s1_q.bot_ok;
    col_in.first  = s1_q.first;
    col_in.lastc  = s1_q.lastc;
  end

  // chain of window cells: right, centre, left
  assign shift  = adv && s1_valid_q && s1_q.line;
  assign centre = col[1].mid;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    lbp_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .col_i    ((i == 0) ? col_in : col[(i == 0) ? 0 : i - 1]),
      .centre_i (centre),
      .col_o    (col[i]),
      .ge_o     (ge[i])
    );
  end

  // second stage flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q.read <= s1_q.read;
      s2_q.clr  <= s1_q.clr;
      s2_q.emit <= s1_q.emit;
      s2_q.last <= s1_q.last;
      s2_q.bin  <= s1_q.bin;
    end
  end

  // pattern bits clockwise from the top-left
  always_comb begin
    lbp[0] = ge[2][0] && !col[1].first;
    lbp[1] = ge[1][0];
    lbp[2] = ge[0][0] && !col[1].lastc;
    lbp[3] = ge[0][1] && !col[1].lastc;
    lbp[4] = ge[0][2] && !col[1].lastc;
    lbp[5] = ge[1][2];
    lbp[6] = ge[2][2] && !col[1].first;
    lbp[7] = ge[2][1] && !col[1].first;
  end

  // histogram request
  always_comb begin
    hist_req.valid = s2_valid_q && (s2_q.read || s2_q.emit || s2_q.clr);
    hist_req.last  = s2_q.last;
    if (s2_q.read) begin
      hist_req.op   = lbp_pkg::HOP_READ;
      hist_req.addr = s2_q.bin;
    end else if (s2_q.emit) begin
      hist_req.op   = lbp_pkg::HOP_CODE;
      hist_req.addr = lbp;
    end else begin
      hist_req.op   = lbp_pkg::HOP_CLEAR;
      hist_req.addr = lbp;
    end
  end

  lbp_hist u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .req_i       (hist_req),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // two-word output buffer, head word in ob0
  assign push = adv && res_valid;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    ob_cnt_d = ob_cnt_q;
    ob0_d    = ob0_q;
    ob1_d    = ob1_q;
    case (ob_cnt_q)
      2'd0: begin
        if (push) begin
          ob0_d    = res;
          ob_cnt_d = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          ob0_d = res;
        end else if (push) begin
          ob1_d    = res;
          ob_cnt_d = 2'd2;
        end else if (pop) begin
          ob_cnt_d = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          ob0_d    = ob1_q;
          ob_cnt_d = 2'd1;
        end
      end
      default: ob_cnt_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_cnt_q <= 2'd0;
    end else begin
      ob_cnt_q <= ob_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob0_q <= ob0_d;
    ob1_q <= ob1_d;
  end

  assign out_valid_o  = (ob_cnt_q != 2'd0);
  assign kind_o       = ob0_q.kind;
  assign code_o       = ob0_q.code;
  assign count_o      = ob0_q.count;
  assign frame_done_o = ob0_q.frame_done;

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbp_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic                      kind_o,
  input wire logic [lbp_pkg::PIX_W-1:0] code_o,
  input wire logic [lbp_pkg::CNT_W-1:0] count_o,
  input wire logic                      frame_done_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(code_o)
      && $stable(count_o) && $stable(frame_done_o))
    else $error("result word changed while stalled");

  // code words carry no count
  a_code_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == lbp_pkg::KIND_CODE) |-> (count_o == '0))
    else $error("code word with non-zero count");

  // count words never flag a frame end
  a_count_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == lbp_pkg::KIND_COUNT) |-> !frame_done_o)
    else $error("count word flagged as frame end");

  // an empty output buffer never holds off the input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind lbp_image_with_histogram_top lbp_checker u_lbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_o       (kind_o),
  .code_o       (code_o),
  .count_o      (count_o),
  .frame_done_o (frame_done_o)
);

`default_nettype wire

// ===== verif/lbp_image_with_histogram_top_tb.sv =====
`timescale 1ns / 1ps

module lbp_image_with_histogram_top_tb;
  import lbp_pkg::*;

  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int MAX_H         = DEF_MAX_HEIGHT;
  localparam int RING_LEN      = 2 * MAX_W + 2;
  localparam int RANDOM_WORDS  = 1700;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 500000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [CMD_W-1:0]     cmd_i;
  logic [PIX_W-1:0]     pixel_i;
  logic [BIN_W-1:0]     bin_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 kind_o;
  logic [PIX_W-1:0]     code_o;
  logic [CNT_W-1:0]     count_o;
  logic                 frame_done_o;

  lbp_image_with_histogram_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .pixel_i      (pixel_i),
    .bin_i        (bin_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .code_o       (code_o),
    .count_o      (count_o),
    .frame_done_o (frame_done_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predictor state: registers, recent pixels, bins and frame position
  logic [CFG_W-1:0] reg_width;
  logic [CFG_W-1:0] reg_height;
  logic [PIX_W-1:0] seen_pix [RING_LEN];
  logic [CNT_W-1:0] bin_count [NUM_BINS];
  logic [PIX_W-1:0] last_code;
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      word_num;
  int unsigned      cur_w;
  int unsigned      cur_h;
  bit               in_frame;
  res_t             result_q [$];

  // neighbour offsets, clockwise from the top-left
  int nb_row [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};
  int nb_col [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};

  int mismatches      = 0;
  int effective_words = 0;
  int burst_left      = 0;
  int cycle_count     = 0;
  int stall_mode      = 0;
  int mode_left       = 0;

  function automatic int unsigned size_clamp(logic [CFG_W-1:0] v, int unsigned top);
    if (v == '0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // works out the result of one accepted word; returns 1 unless ignored
  function automatic bit predict_word(cmd_e cmd, logic [PIX_W-1:0] pix,
                                      logic [BIN_W-1:0] bin);
    res_t             r;
    bit               is_pix;
    bit               last;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] code;
    int               nr;
    int               nc;
    int unsigned      q;
    r = '0;
    is_pix = (cmd == CMD_PIXEL);
    case (cmd)
      CMD_READ: begin
        r.kind  = KIND_COUNT;
        r.code  = bin;
        r.count = bin_count[bin];
        result_q.push_back(r);
        return 1;
      end
      CMD_PIXEL: begin
        // a pixel outside a frame opens one
        if (!in_frame) begin
          cur_w = size_clamp(reg_width, MAX_W);
          cur_h = size_clamp(reg_height, MAX_H);
          foreach (bin_count[i]) bin_count[i] = '0;
          col_pos  = 0;
          row_pos  = 0;
          word_num = 0;
          in_frame = 1'b1;
        end
        if (word_num >= cur_w * cur_h) return 0;
      end
      CMD_DRAIN: begin
        if (!in_frame || word_num < cur_w * cur_h) return 0;
      end
      default: return 0;
    endcase

    // code of the delayed centre pixel
    if (word_num >= cur_w + 1) begin
      centre = seen_pix[(word_num - cur_w - 1) % RING_LEN];
      code = '0;
      for (int n = 0; n < 8; n++) begin
        nr = int'(row_pos) + nb_row[n];
        nc = int'(col_pos) + nb_col[n];
        if (nr >= 0 && nr < int'(cur_h) && nc >= 0 && nc < int'(cur_w)) begin
          q = nr * cur_w + nc;
          if (q == word_num) v = is_pix ? pix : '0;
          else v = seen_pix[q % RING_LEN];
          if (v >= centre) code[n] = 1'b1;
        end
      end
      if (bin_count[code] != CNT_MAX) bin_count[code] = bin_count[code] + 1'b1;
      last = (row_pos == cur_h - 1) && (col_pos == cur_w - 1);
      r.kind       = KIND_CODE;
      r.code       = code;
      r.frame_done = last;
      result_q.push_back(r);
      last_code = code;
      if (last) in_frame = 1'b0;
      if (col_pos + 1 >= cur_w) begin
        col_pos = 0;
        row_pos = row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    end
    if (is_pix) seen_pix[word_num % RING_LEN] = pix;
    word_num = word_num + 1;
    return 1;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 3))
      0: return PIX_W'($urandom_range(126, 130));
      1: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // sends one input word in bursts with random gaps
  task automatic send_word(cmd_e cmd, logic [PIX_W-1:0] pix, logic [BIN_W-1:0] bin);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    cmd_i      = cmd;
    pixel_i    = pix;
    bin_i      = bin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_word(cmd, pix, bin)) effective_words++;
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_word(CMD_READ, PIX_W'($urandom), BIN_W'($urandom));
      1: send_word(CMD_NOP, PIX_W'($urandom), BIN_W'($urandom));
      default: send_word(CMD_DRAIN, PIX_W'($urandom), BIN_W'($urandom));
    endcase
  endtask

  task automatic send_pixels(int unsigned n);
    repeat (n) send_word(CMD_PIXEL, rand_pixel(), BIN_W'($urandom));
  endtask

  task automatic send_drains(int unsigned n);
    repeat (n) send_word(CMD_DRAIN, PIX_W'($urandom), BIN_W'($urandom));
  endtask

  task automatic read_all_bins();
    for (int b = 0; b < NUM_BINS; b++) send_word(CMD_READ, PIX_W'($urandom), BIN_W'(b));
  endtask

  // stop sending and let the pipeline empty
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_FRAME_WIDTH) reg_width = val;
    else reg_height = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // bins read as zero after reset; drain and nop outside a frame do nothing
  task automatic test_reset_state();
    send_word(CMD_READ, '0, '0);
    send_word(CMD_READ, '1, '1);
    send_word(CMD_NOP, '1, '1);
    send_word(CMD_DRAIN, '0, '0);
    send_word(CMD_READ, 8'h5a, 8'ha5);
  endtask

  // small frame with equal neighbours, early drain, extra pixel and reads
  task automatic test_directed_frame();
    configure(3, 3);
    send_word(CMD_PIXEL, 8'd100, '1);
    send_word(CMD_PIXEL, 8'd100, '0);
    send_word(CMD_PIXEL, 8'd255, '0);
    send_word(CMD_PIXEL, 8'd0, '0);
    send_word(CMD_DRAIN, '0, '0);
    send_word(CMD_READ, '0, '0);
    send_word(CMD_PIXEL, 8'd100, '0);
    send_word(CMD_NOP, '0, '0);
    send_word(CMD_PIXEL, 8'd255, '0);
    send_word(CMD_PIXEL, 8'd100, '0);
    send_word(CMD_PIXEL, 8'd0, '0);
    send_word(CMD_PIXEL, 8'd99, '0);
    send_word(CMD_PIXEL, 8'd255, '0);
    send_word(CMD_READ, '1, '1);
    send_drains(4);
    send_word(CMD_DRAIN, '1, '1);
    read_all_bins();
  endtask

  // smallest, largest and saturated frame sizes
  task automatic test_size_extremes();
    configure(1, 1);
    send_pixels(1);
    send_drains(2);
    send_word(CMD_READ, '0, '0);
    configure(0, 0);
    send_pixels(1);
    send_drains(2);
    send_word(CMD_READ, '0, '0);
    configure(11'h7ff, 1);
    send_pixels(MAX_W);
    send_drains(MAX_W + 1);
    send_word(CMD_READ, '0, last_code);
    configure(1, MAX_H);
    send_pixels(MAX_H);
    send_drains(2);
    send_word(CMD_READ, '0, last_code);
    configure(MAX_W, 3);
    send_pixels(3 * MAX_W);
    send_drains(MAX_W + 1);
    read_all_bins();
  endtask

  // sizes written mid-frame only apply from the next frame
  task automatic test_midframe_config();
    configure(4, 3);
    send_pixels(5);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 7);
    write_reg(REG_FRAME_HEIGHT, 2);
    send_pixels(7);
    send_drains(5);
    send_word(CMD_READ, '0, last_code);
    send_pixels(14);
    send_drains(8);
    send_word(CMD_READ, '0, last_code);
  endtask

  // well-formed frames of random size with noise words mixed in
  task automatic test_random_frames();
    int unsigned      start;
    int unsigned      fw;
    int unsigned      fh;
    int unsigned      n;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    start = effective_words;
    while (effective_words - start < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 24))
          0: begin
            w = CFG_W'($urandom_range(MAX_W + 1, 2047));
            h = CFG_W'($urandom_range(0, 2));
          end
          1: begin
            w = CFG_W'($urandom_range(0, 1));
            h = CFG_W'($urandom_range(MAX_H + 1, 2047));
          end
          2, 3, 4: begin
            w = CFG_W'($urandom_range(1, 40));
            h = CFG_W'($urandom_range(1, 6));
          end
          default: begin
            w = CFG_W'($urandom_range(1, 10));
            h = CFG_W'($urandom_range(1, 8));
          end
        endcase
        wait_idle();
        if ($urandom_range(0, 4) != 0) write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
      end
      fw = size_clamp(reg_width, MAX_W);
      fh = size_clamp(reg_height, MAX_H);
      for (n = 0; n < fw * fh; n++) begin
        if ($urandom_range(0, 11) == 0) send_noise();
        // register change while the frame runs
        if (n > 0 && n == fw * fh / 2 && $urandom_range(0, 9) == 0) begin
          wait_idle();
          write_reg(reg_idx_e'($urandom_range(0, 1)), CFG_W'($urandom_range(1, 12)));
        end
        send_word(CMD_PIXEL, rand_pixel(), BIN_W'($urandom));
      end
      // pixels past the frame's end, ignored until the last code
      if ($urandom_range(0, 3) == 0) send_pixels($urandom_range(1, 3));
      for (n = 0; n < fw + 1; n++) begin
        if ($urandom_range(0, 11) == 0) send_noise();
        send_word(CMD_DRAIN, PIX_W'($urandom), BIN_W'($urandom));
      end
      if ($urandom_range(0, 4) == 0) send_drains(1);
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 1) != 0) send_word(CMD_READ, PIX_W'($urandom), last_code);
        else send_word(CMD_READ, PIX_W'($urandom), BIN_W'($urandom));
      end
    end
  endtask

  // receiver stall pattern, changing mode every so often
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ~out_ready_i;
    endcase
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: kind %0d code %0d count %0d done %0d",
                   kind_o, code_o, count_o, frame_done_o);
      end else begin
        want = result_q.pop_front();
        if (kind_o !== want.kind || code_o !== want.code || count_o !== want.count ||
            frame_done_o !== want.frame_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected kind %0d code %0d count %0d done %0d, got kind %0d code %0d count %0d done %0d",
                     want.kind, want.code, want.count, want.frame_done,
                     kind_o, code_o, count_o, frame_done_o);
        end
      end
    end
  end

  // run time limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // reset, then the tests in turn
  initial begin
    in_valid_i  = 1'b0;
    cmd_i       = CMD_NOP;
    pixel_i     = '0;
    bin_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_FRAME_WIDTH;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    reg_width   = CFG_SIZE_RST;
    reg_height  = CFG_SIZE_RST;
    foreach (seen_pix[i]) seen_pix[i] = '0;
    foreach (bin_count[i]) bin_count[i] = '0;
    last_code = '0;
    col_pos   = 0;
    row_pos   = 0;
    word_num  = 0;
    cur_w     = CFG_SIZE_RST;
    cur_h     = CFG_SIZE_RST;
    in_frame  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_directed_frame();
    test_size_extremes();
    test_midframe_config();
    test_random_frames();

    wait_idle();
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lbp_pkg.sv
hw/rtl/lbp_ram.sv
hw/rtl/lbp_cell.sv
hw/rtl/lbp_hist.sv
hw/rtl/lbp_image_with_histogram_top.sv
hw/rtl/lbp_checker.sv
verif/lbp_image_with_histogram_top_tb.sv
